FILE: hdl/las_pkg.sv
// Shared types for the longest alternating subsequence block: sequencer states and compare result.
package las_pkg;

	typedef enum logic [4:0] {
		S_LOAD,
		S_PUSH,
		S_T1,
		S_V1,
		S_C1,
		S_VL,
		S_L1,
		S_VL2,
		S_L2,
		S_TOP,
		S_VB,
		S_CB,
		S_CC,
		S_DEC,
		S_SR,
		S_SC,
		S_SD,
		S_EM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_t;

endpackage

FILE: hdl/las_ram.sv
// Generic single-write, single-read RAM with registered read data.
module las_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/las_cmp.sv
// Shared signed comparator used by the load step and the compare steps of the sequencer.
module las_cmp #(
	parameter int W = 32
) (
	input  logic signed [W-1:0] x,
	input  logic signed [W-1:0] y,
	output las_pkg::cmp_t       res
);

	always_comb begin
		res.lt = (x < y);
		res.eq = (x == y);
		res.gt = (x > y);
	end

endmodule

FILE: hdl/longest_alternating_subsequence.sv
// Top level: loads a sequence and emits a longest alternating subsequence of it.
//
//   channel  | handshake                   | fields
//   ---------+-----------------------------+--------------------
//   input    | valid / stall               | sample, is_final
//   output   | picked_valid / picked_stall | picked, end_of_run
//
// Loading accepts one word per cycle while stall is low; items past MAX_ITEMS are dropped.
// After the final word the pass walks the turning points and moves extrema back, its pace
// set by the single read port of the value memory and the one shared comparator;
// input stall is high meanwhile. A stalled output adds its stall cycles to the pass.
// Reset clears the state, counters and flags only; the data registers are not reset.
module longest_alternating_subsequence #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	output logic                         stall,
	input  logic signed [VALUE_BITS-1:0] sample,
	input  logic                         is_final,
	output logic                         picked_valid,
	input  logic                         picked_stall,
	output logic signed [VALUE_BITS-1:0] picked,
	output logic                         end_of_run
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	las_pkg::state_t state_q, state_d;

	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] tcnt_q, tcnt_d;
	logic [CW-1:0] tc_q, tc_d;
	logic [CW-1:0] i_q, i_d;
	logic          up_q, up_d, up_new;
	logic          drop_q, drop_d;
	logic          hn_q, hn_d;
	logic          dir_q, dir_d;
	logic          out_valid_q;

	logic [AW-1:0] a_q, a_d;
	logic [AW-1:0] b_q, b_d;
	logic [AW-1:0] m_q, m_d;

	logic signed [VALUE_BITS-1:0] prev_q, prev_d;
	logic signed [VALUE_BITS-1:0] va_q, va_d;
	logic signed [VALUE_BITS-1:0] vb_q, vb_d;
	logic signed [VALUE_BITS-1:0] vc_q, vc_d;
	logic signed [VALUE_BITS-1:0] vm_q, vm_d;
	logic signed [VALUE_BITS-1:0] x_q, x_d;
	logic signed [VALUE_BITS-1:0] pv_q, pv_d;
	logic signed [VALUE_BITS-1:0] picked_q;
	logic                         end_q;

	logic                  val_we;
	logic [AW-1:0]         val_waddr;
	logic [VALUE_BITS-1:0] val_wdata;
	logic [AW-1:0]         val_raddr;
	logic [VALUE_BITS-1:0] val_rdata;

	logic          turn_we;
	logic [AW-1:0] turn_waddr;
	logic [AW-1:0] turn_wdata;
	logic [AW-1:0] turn_raddr;
	logic [AW-1:0] turn_rdata;

	logic signed [VALUE_BITS-1:0] cmp_x, cmp_y;
	las_pkg::cmp_t                res;
	logic                         cmp_go;

	logic          push, push_end;
	logic          slot_free;
	logic [CW:0]   i1, i2, tc_x;
	logic [AW:0]   a1;

	las_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	las_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_turn_ram (
		.clk   (clk),
		.we    (turn_we),
		.waddr (turn_waddr),
		.wdata (turn_wdata),
		.raddr (turn_raddr),
		.rdata (turn_rdata)
	);

	las_cmp #(.W(VALUE_BITS)) u_cmp (
		.x   (cmp_x),
		.y   (cmp_y),
		.res (res)
	);

	assign cmp_go    = dir_q ? res.lt : res.gt;
	assign slot_free = !out_valid_q || !picked_stall;
	assign i1        = {1'b0, i_q} + (CW+1)'(1);
	assign i2        = {1'b0, i_q} + (CW+1)'(2);
	assign tc_x      = {1'b0, tc_q};
	assign a1        = {1'b0, a_q} + (AW+1)'(1);
	assign up_new    = (cnt_q == CW'(1)) ? !res.gt : up_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		tcnt_d     = tcnt_q;
		tc_d       = tc_q;
		i_d        = i_q;
		up_d       = up_q;
		drop_d     = drop_q;
		hn_d       = hn_q;
		dir_d      = dir_q;
		a_d        = a_q;
		b_d        = b_q;
		m_d        = m_q;
		prev_d     = prev_q;
		va_d       = va_q;
		vb_d       = vb_q;
		vc_d       = vc_q;
		vm_d       = vm_q;
		x_d        = x_q;
		pv_d       = pv_q;
		val_we     = 1'b0;
		val_waddr  = cnt_q[AW-1:0];
		val_wdata  = sample;
		val_raddr  = '0;
		turn_we    = 1'b0;
		turn_waddr = tcnt_q[AW-1:0];
		turn_wdata = '0;
		turn_raddr = '0;
		cmp_x      = va_q;
		cmp_y      = vb_q;
		push       = 1'b0;
		push_end   = 1'b0;
		case (state_q)
			las_pkg::S_LOAD: begin
				cmp_x = prev_q;
				cmp_y = sample;
				if (valid) begin
					if (cnt_q < CW'(MAX_ITEMS)) begin
						val_we = 1'b1;
						prev_d = sample;
						cnt_d  = cnt_q + CW'(1);
						if (cnt_q == '0) begin
							turn_we    = 1'b1;
							turn_waddr = '0;
							turn_wdata = '0;
							tcnt_d     = CW'(1);
						end else begin
							up_d = up_new;
							if ((res.lt && !up_new) || (res.gt && up_new)) begin
								up_d = res.lt;
								if (tcnt_q < CW'(MAX_ITEMS)) begin
									turn_we    = 1'b1;
									turn_wdata = AW'(cnt_q - CW'(1));
									tcnt_d     = tcnt_q + CW'(1);
								end
							end
						end
					end
					if (is_final) begin
						state_d = las_pkg::S_PUSH;
					end
				end
			end
			las_pkg::S_PUSH: begin
				if (tcnt_q < CW'(MAX_ITEMS)) begin
					turn_we    = 1'b1;
					turn_wdata = AW'(cnt_q - CW'(1));
					tcnt_d     = tcnt_q + CW'(1);
				end
				state_d = las_pkg::S_T1;
			end
			las_pkg::S_T1: begin
				va_d       = val_rdata;
				pv_d       = val_rdata;
				a_d        = '0;
				i_d        = '0;
				turn_raddr = AW'(1);
				state_d    = las_pkg::S_V1;
			end
			las_pkg::S_V1: begin
				val_raddr = turn_rdata;
				state_d   = las_pkg::S_C1;
			end
			las_pkg::S_C1: begin
				cmp_x      = va_q;
				cmp_y      = val_rdata;
				drop_d     = res.eq;
				tc_d       = tcnt_q - CW'(res.eq);
				turn_raddr = AW'(tcnt_q - CW'(1));
				if (tc_d > CW'(1)) begin
					state_d = las_pkg::S_VL;
				end else begin
					state_d = las_pkg::S_TOP;
				end
			end
			las_pkg::S_VL: begin
				val_raddr = turn_rdata;
				state_d   = las_pkg::S_L1;
			end
			las_pkg::S_L1: begin
				x_d   = val_rdata;
				cmp_x = val_rdata;
				cmp_y = va_q;
				if (tc_q == CW'(2)) begin
					tc_d    = tc_q - CW'(res.eq);
					state_d = las_pkg::S_TOP;
				end else begin
					turn_raddr = AW'(tcnt_q - CW'(2));
					state_d    = las_pkg::S_VL2;
				end
			end
			las_pkg::S_VL2: begin
				val_raddr = turn_rdata;
				state_d   = las_pkg::S_L2;
			end
			las_pkg::S_L2: begin
				cmp_x   = x_q;
				cmp_y   = val_rdata;
				tc_d    = tc_q - CW'(res.eq);
				state_d = las_pkg::S_TOP;
			end
			las_pkg::S_TOP: begin
				if (i1 >= tc_x) begin
					state_d = las_pkg::S_DONE;
				end else begin
					turn_raddr = AW'(i1 + (CW+1)'(drop_q));
					state_d    = las_pkg::S_VB;
				end
			end
			las_pkg::S_VB: begin
				b_d       = turn_rdata;
				val_raddr = turn_rdata;
				hn_d      = (i2 < tc_x);
				if (i2 < tc_x) begin
					turn_raddr = AW'(i2 + (CW+1)'(drop_q));
				end
				state_d = las_pkg::S_CB;
			end
			las_pkg::S_CB: begin
				vb_d = val_rdata;
				if (hn_q) begin
					val_raddr = turn_rdata;
					state_d   = las_pkg::S_CC;
				end else begin
					state_d = las_pkg::S_DEC;
				end
			end
			las_pkg::S_CC: begin
				vc_d    = val_rdata;
				state_d = las_pkg::S_DEC;
			end
			las_pkg::S_DEC: begin
				cmp_x = vb_q;
				cmp_y = va_q;
				if ({1'b0, b_q} > a1) begin
					if (res.eq) begin
						a_d     = b_q;
						va_d    = vb_q;
						i_d     = i_q + CW'(1);
						state_d = las_pkg::S_TOP;
					end else begin
						dir_d   = res.lt;
						m_d     = b_q;
						vm_d    = vb_q;
						state_d = las_pkg::S_SR;
					end
				end else begin
					a_d     = b_q;
					va_d    = vb_q;
					state_d = las_pkg::S_EM;
				end
			end
			las_pkg::S_SR: begin
				if ({1'b0, m_q} > a1) begin
					val_raddr = m_q - AW'(1);
					state_d   = las_pkg::S_SC;
				end else begin
					a_d     = m_q;
					va_d    = vm_q;
					state_d = las_pkg::S_EM;
				end
			end
			las_pkg::S_SC: begin
				x_d   = val_rdata;
				cmp_x = val_rdata;
				cmp_y = va_q;
				if (!cmp_go) begin
					a_d     = m_q;
					va_d    = vm_q;
					state_d = las_pkg::S_EM;
				end else if (hn_q) begin
					state_d = las_pkg::S_SD;
				end else begin
					m_d     = m_q - AW'(1);
					vm_d    = val_rdata;
					state_d = las_pkg::S_SR;
				end
			end
			las_pkg::S_SD: begin
				cmp_x = x_q;
				cmp_y = vc_q;
				if (cmp_go) begin
					m_d     = m_q - AW'(1);
					vm_d    = x_q;
					state_d = las_pkg::S_SR;
				end else begin
					a_d     = m_q;
					va_d    = vm_q;
					state_d = las_pkg::S_EM;
				end
			end
			las_pkg::S_EM: begin
				if (slot_free) begin
					push    = 1'b1;
					pv_d    = va_q;
					i_d     = i_q + CW'(1);
					state_d = las_pkg::S_TOP;
				end
			end
			las_pkg::S_DONE: begin
				if (slot_free) begin
					push     = 1'b1;
					push_end = 1'b1;
					cnt_d    = '0;
					tcnt_d   = '0;
					up_d     = 1'b1;
					state_d  = las_pkg::S_LOAD;
				end
			end
			default: begin
				state_d = las_pkg::S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= las_pkg::S_LOAD;
			cnt_q       <= '0;
			tcnt_q      <= '0;
			tc_q        <= '0;
			i_q         <= '0;
			up_q        <= 1'b1;
			drop_q      <= 1'b0;
			hn_q        <= 1'b0;
			dir_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			tcnt_q  <= tcnt_d;
			tc_q    <= tc_d;
			i_q     <= i_d;
			up_q    <= up_d;
			drop_q  <= drop_d;
			hn_q    <= hn_d;
			dir_q   <= dir_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!picked_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_q    <= a_d;
		b_q    <= b_d;
		m_q    <= m_d;
		prev_q <= prev_d;
		va_q   <= va_d;
		vb_q   <= vb_d;
		vc_q   <= vc_d;
		vm_q   <= vm_d;
		x_q    <= x_d;
		pv_q   <= pv_d;
		if (push) begin
			picked_q <= pv_q;
			end_q    <= push_end;
		end
	end

	assign stall        = (state_q != las_pkg::S_LOAD);
	assign picked_valid = out_valid_q;
	assign picked       = picked_q;
	assign end_of_run   = end_q;

endmodule

FILE: hdl/las_check.sv
// Port-level checker for the longest alternating subsequence block, bound to the top level.
module las_check #(
	parameter int VALUE_BITS = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         valid,
	input logic                         stall,
	input logic signed [VALUE_BITS-1:0] sample,
	input logic                         is_final,
	input logic                         picked_valid,
	input logic                         picked_stall,
	input logic signed [VALUE_BITS-1:0] picked,
	input logic                         end_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		picked_valid && picked_stall |=>
			picked_valid && $stable(picked) && $stable(end_of_run))
		else $error("output word changed while stalled");

	a_final_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !stall && is_final |=> stall)
		else $error("input not stalled after the final word");

	a_word_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(picked_valid) |-> $past(stall))
		else $error("output word appeared outside the final pass");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !stall && !is_final && !picked_valid |=> !picked_valid)
		else $error("output word produced by a non-final input word");

endmodule

bind longest_alternating_subsequence las_check #(.VALUE_BITS(VALUE_BITS)) u_las_check (.*);

FILE: sim/tb_longest_alternating_subsequence.sv
// Self-checking testbench for the longest alternating subsequence block.
module tb_longest_alternating_subsequence;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXN = 64;
	localparam int VB = 32;
	localparam logic signed [VB-1:0] VMIN = 32'sh8000_0000;
	localparam logic signed [VB-1:0] VMAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic signed [VB-1:0] value;
		logic last;
	} pick_t;

	typedef struct packed {
		logic signed [VB-1:0] sample;
		logic fin;
		bit typed;
		logic signed [VB-1:0] want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic stall;
	logic signed [VB-1:0] sample = '0;
	logic is_final = 1'b0;
	logic picked_valid;
	logic picked_stall = 1'b0;
	logic signed [VB-1:0] picked;
	logic end_of_run;

	pick_t expected_picks[$];
	pick_t new_picks[$];
	int unsigned mismatches = 0;
	int unsigned sent_words = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	bit hold_long = 1'b0;

	logic signed [VB-1:0] seq_vals [MAXN];
	logic [5:0] turn_idx [MAXN];
	int unsigned n_loaded = 0;
	int unsigned n_turns = 0;
	bit rising = 1'b1;

	stim_row_t rows [26] = '{
		'{VMIN, 1'b1, 1'b1, VMIN},
		'{VMAX, 1'b1, 1'b1, VMAX},
		'{32'sd0, 1'b1, 1'b1, 32'sd0},
		'{-32'sd1, 1'b1, 1'b1, -32'sd1},
		'{32'sd7, 1'b0, 1'b0, 32'sd0},
		'{32'sd7, 1'b0, 1'b0, 32'sd0},
		'{32'sd7, 1'b1, 1'b0, 32'sd0},
		'{VMIN, 1'b0, 1'b0, 32'sd0},
		'{VMAX, 1'b1, 1'b0, 32'sd0},
		'{VMAX, 1'b0, 1'b0, 32'sd0},
		'{VMIN, 1'b1, 1'b0, 32'sd0},
		'{32'sd1, 1'b0, 1'b0, 32'sd0},
		'{32'sd5, 1'b0, 1'b0, 32'sd0},
		'{32'sd3, 1'b0, 1'b0, 32'sd0},
		'{32'sd3, 1'b0, 1'b0, 32'sd0},
		'{32'sd9, 1'b0, 1'b0, 32'sd0},
		'{32'sd2, 1'b1, 1'b0, 32'sd0},
		'{32'sd0, 1'b0, 1'b0, 32'sd0},
		'{32'sd1, 1'b0, 1'b0, 32'sd0},
		'{32'sd2, 1'b0, 1'b0, 32'sd0},
		'{32'sd3, 1'b0, 1'b0, 32'sd0},
		'{-32'sd5, 1'b1, 1'b0, 32'sd0},
		'{32'sd4, 1'b0, 1'b0, 32'sd0},
		'{32'sd4, 1'b0, 1'b0, 32'sd0},
		'{-32'sd2, 1'b0, 1'b0, 32'sd0},
		'{-32'sd2, 1'b1, 1'b0, 32'sd0}
	};

	longest_alternating_subsequence dut (
		.clk(clk),
		.arst_n(arst_n),
		.valid(valid),
		.stall(stall),
		.sample(sample),
		.is_final(is_final),
		.picked_valid(picked_valid),
		.picked_stall(picked_stall),
		.picked(picked),
		.end_of_run(end_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 50)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void add_turn(input int unsigned idx);
		if (n_turns < MAXN) begin
			turn_idx[n_turns] = idx[5:0];
			n_turns++;
		end
	endfunction

	function automatic void add_pick(input logic signed [VB-1:0] v);
		if (new_picks.size() < MAXN)
			new_picks.insert(new_picks.size(), '{value: v, last: 1'b0});
	endfunction

	function automatic void zigzag_step(input logic signed [VB-1:0] s, input logic fin);
		int unsigned idx, len, tc, a, b, c, m;
		int unsigned t [MAXN];
		bit has_nn;
		new_picks.delete();
		if (n_loaded < MAXN) begin
			idx = n_loaded;
			seq_vals[idx] = s;
			if (idx == 0) begin
				n_turns = 0;
				add_turn(0);
			end else begin
				if (idx == 1)
					rising = !(seq_vals[0] > seq_vals[1]);
				if (seq_vals[idx] > seq_vals[idx-1] && !rising) begin
					rising = 1'b1;
					add_turn(idx - 1);
				end
				if (seq_vals[idx-1] > seq_vals[idx] && rising) begin
					rising = 1'b0;
					add_turn(idx - 1);
				end
			end
			n_loaded++;
		end
		if (!fin)
			return;
		len = n_loaded;
		if (len <= 1) begin
			add_pick(seq_vals[0]);
		end else begin
			add_turn(len - 1);
			tc = n_turns;
			for (int i = 0; i < tc; i++)
				t[i] = turn_idx[i];
			if (tc > 1 && seq_vals[t[0]] == seq_vals[t[1]]) begin
				for (int i = 1; i + 1 < tc; i++)
					t[i] = t[i+1];
				tc--;
			end
			if (tc > 1 && seq_vals[t[tc-1]] == seq_vals[t[tc-2]])
				tc--;
			add_pick(seq_vals[0]);
			for (int i = 0; i + 1 < tc; i++) begin
				a = t[i];
				b = t[i+1];
				has_nn = (i + 2 < tc);
				c = has_nn ? t[i+2] : 0;
				if (b > a + 1) begin
					m = b;
					if (seq_vals[b] < seq_vals[a]) begin
						while (m > a + 1 && seq_vals[m-1] < seq_vals[a]) begin
							if (has_nn && seq_vals[m-1] >= seq_vals[c])
								break;
							m--;
						end
						add_pick(seq_vals[m]);
						t[i+1] = m;
					end else if (seq_vals[b] > seq_vals[a]) begin
						while (m > a + 1 && seq_vals[m-1] > seq_vals[a]) begin
							if (has_nn && seq_vals[m-1] <= seq_vals[c])
								break;
							m--;
						end
						add_pick(seq_vals[m]);
						t[i+1] = m;
					end
				end else begin
					add_pick(seq_vals[b]);
				end
			end
		end
		new_picks[new_picks.size()-1].last = 1'b1;
		n_loaded = 0;
		n_turns = 0;
		rising = 1'b1;
	endfunction

	function automatic logic signed [VB-1:0] pick_value(input int unsigned style);
		case (style)
			0: return $urandom;
			1: return int'($urandom_range(0, 6)) - 3;
			2: return ($urandom_range(0, 1) ? VMAX : VMIN) ^ $urandom_range(0, 3);
			default: return int'($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	task automatic send_word(input logic signed [VB-1:0] s, input logic fin, input bit typed,
			input logic signed [VB-1:0] want);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		valid <= 1'b1;
		sample <= s;
		is_final <= fin;
		do @(posedge clk); while (stall !== 1'b0);
		zigzag_step(s, fin);
		if (typed)
			expected_picks.insert(expected_picks.size(), '{value: want, last: 1'b1});
		else
			foreach (new_picks[k])
				expected_picks.insert(expected_picks.size(), new_picks[k]);
		sent_words++;
	endtask

	initial begin : drive
		int unsigned seq_no, len, style;
		seq_no = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		foreach (rows[r])
			send_word(rows[r].sample, rows[r].fin, rows[r].typed, rows[r].want);
		while (sent_words < 420) begin
			tx_idle = !(sent_words >= 200 && sent_words < 260) && sent_words < 370;
			rx_idle = sent_words < 370;
			if (seq_no == 3)
				hold_long = 1'b1;
			if (seq_no == 9) begin
				valid <= 1'b0;
				do @(posedge clk); while (expected_picks.size() != 0);
			end
			if (seq_no == 3 || seq_no == 4)
				len = 40;
			else if (seq_no % 12 == 6)
				len = $urandom_range(65, 72);
			else if ($urandom_range(0, 7) == 0)
				len = $urandom_range(11, 64);
			else
				len = $urandom_range(1, 10);
			style = $urandom_range(0, 3);
			for (int i = 0; i < len; i++)
				send_word(pick_value(style), i == len - 1, 1'b0, '0);
			seq_no++;
		end
		valid <= 1'b0;
		do @(posedge clk); while (expected_picks.size() != 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb_longest_alternating_subsequence OK");
		else
			$display("tb_longest_alternating_subsequence NOT OK");
		$finish;
	end

	initial begin : receive
		pick_t want;
		int unsigned stall_left;
		bit long_done;
		stall_left = 0;
		long_done = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && picked_valid === 1'b1 && picked_stall == 1'b0) begin
				if (expected_picks.size() == 0) begin
					report_mismatch($sformatf("unexpected word %0d last %0b", picked, end_of_run));
				end else begin
					want = expected_picks.pop_front();
					if (picked !== want.value)
						report_mismatch($sformatf("picked %0d, expected %0d", picked, want.value));
					if (end_of_run !== want.last)
						report_mismatch($sformatf("end_of_run %b, expected %b", end_of_run,
							want.last));
				end
			end
			if (hold_long && !long_done) begin
				long_done = 1'b1;
				stall_left = 400;
			end else if (stall_left == 0 && rx_idle && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 14);
			end
			if (stall_left != 0) begin
				picked_stall <= 1'b1;
				stall_left--;
			end else begin
				picked_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("tb_longest_alternating_subsequence NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
hdl/las_pkg.sv
hdl/las_ram.sv
hdl/las_cmp.sv
hdl/longest_alternating_subsequence.sv
hdl/las_check.sv
sim/tb_longest_alternating_subsequence.sv
